### rtl/btx_pkg.sv
// Package for the binary trie maximum-XOR lookup block.
// Sizes, derived widths, codes and the controller/datapath signal bundles.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package btx_pkg;

   localparam int KEY_BITS   = 32;
   localparam int NODE_COUNT = 65536;
   localparam int ID_BITS    = 16;

   localparam int KEY_W = 32;
   localparam int EID_W = 16;
   localparam int PID_W = 16;
   localparam int STS_W = 2;

   localparam int NODE_W = (NODE_COUNT > 2) ? $clog2(NODE_COUNT) : 1;
   localparam int LINK_W = 2 * NODE_W;
   localparam int LVL_W  = $clog2(KEY_BITS + 1);
   localparam int SUM_W  = ((NODE_W > LVL_W) ? NODE_W : LVL_W) + 1;

   localparam logic [SUM_W-1:0]  POOL_LIMIT = SUM_W'(NODE_COUNT - 1);
   localparam logic [NODE_W-1:0] NODE_LIMIT = NODE_W'(NODE_COUNT - 1);

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_QUERY  = 1'b1;

   typedef enum logic [STS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic       accept;
      logic       query_mode;
      logic       walk_step;
      logic       walk_rd_link;
      logic       walk_rd_leaf;
      logic       walk_wr_leaf;
      logic       alloc;
      logic       alloc_first;
      logic       wr_leaf_new;
      logic       load_rsp;
      logic       rsp_use_leaf;
      status_type rsp_status;
   } ctrl_cmd_type;

   typedef struct packed {
      logic req_valid;
      logic req_query;
      logic empty;
      logic miss;
      logic last;
      logic pool_ok;
      logic rsp_busy;
   } dp_stat_type;

endpackage

`default_nettype wire

### rtl/btx_if.sv
// Request and response channel interfaces for the trie lookup block.
// Depends on btx_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface btx_req_if
   import btx_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic             cmd;
   logic [KEY_W-1:0] key;
   logic [EID_W-1:0] entry_id;

   modport source (output valid, output cmd, output key, output entry_id, input ready);
   modport sink   (input valid, input cmd, input key, input entry_id, output ready);
endinterface

interface btx_rsp_if
   import btx_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic [PID_W-1:0] partner_id;
   logic [STS_W-1:0] status;

   modport source (output valid, output partner_id, output status, input ready);
   modport sink   (input valid, input partner_id, input status, output ready);
endinterface

`default_nettype wire

### rtl/btx_datapath.sv
// Datapath of the trie lookup block: node link memory, leaf id memory,
// key shifter, level counter, node pool counter and response register.
// Depends on btx_pkg and btx_if; driven by btx_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module btx_datapath
   import btx_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   btx_req_if.sink           req_bus,
   btx_rsp_if.source         rsp_bus,
   input  wire ctrl_cmd_type cmd,
   output dp_stat_type       stat
);

   logic [LINK_W-1:0]   link_mem [NODE_COUNT];
   logic [ID_BITS-1:0]  leaf_mem [NODE_COUNT];

   logic [KEY_BITS-1:0] walk_ff, walk_in;
   logic [LVL_W-1:0]    levels_ff, levels_in;
   logic [NODE_W-1:0]   node_ff, node_in;
   logic [ID_BITS-1:0]  id_ff, id_in;
   logic [NODE_W-1:0]   nodes_used_ff, nodes_used_in;
   logic                rd_root_ff, rd_root_in;
   logic [LINK_W-1:0]   link_rd_ff;
   logic [ID_BITS-1:0]  leaf_rd_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [PID_W-1:0]    rsp_pid_ff, rsp_pid_in;
   logic [STS_W-1:0]    rsp_status_ff, rsp_status_in;

   logic                accept;
   logic [LINK_W-1:0]   link_word;
   logic [NODE_W-1:0]   child0, child1, same_child, other_child, next_node, new_node;
   logic                cur_bit;
   logic [LINK_W-1:0]   alloc_base, alloc_word;
   logic [SUM_W-1:0]    need_sum;
   logic                link_rd_en;
   logic [NODE_W-1:0]   link_rd_addr;
   logic                leaf_wr_en;
   logic [NODE_W-1:0]   leaf_wr_addr;

   assign accept         = cmd.accept & req_bus.valid;
   assign req_bus.ready  = cmd.accept;

   assign link_word   = (rd_root_ff && nodes_used_ff == '0) ? '0 : link_rd_ff;
   assign child0      = link_word[NODE_W-1:0];
   assign child1      = link_word[LINK_W-1:NODE_W];
   assign cur_bit     = walk_ff[KEY_BITS-1];
   assign same_child  = cur_bit ? child1 : child0;
   assign other_child = cur_bit ? child0 : child1;
   assign next_node   = (cmd.query_mode && other_child != '0) ? other_child : same_child;
   assign new_node    = nodes_used_ff + NODE_W'(1);
   assign alloc_base  = cmd.alloc_first ? link_word : '0;
   assign alloc_word  = cur_bit ? {new_node, alloc_base[NODE_W-1:0]}
                                : {alloc_base[LINK_W-1:NODE_W], new_node};
   assign need_sum    = SUM_W'(nodes_used_ff) + SUM_W'(levels_ff);

   assign link_rd_en   = accept | cmd.walk_rd_link;
   assign link_rd_addr = accept ? '0 : next_node;
   assign leaf_wr_en   = cmd.walk_wr_leaf | cmd.wr_leaf_new;
   assign leaf_wr_addr = cmd.wr_leaf_new ? new_node : next_node;

   assign stat.req_valid = req_bus.valid;
   assign stat.req_query = (req_bus.cmd == CMD_QUERY);
   assign stat.empty     = (nodes_used_ff == '0);
   assign stat.miss      = (same_child == '0);
   assign stat.last      = (levels_ff == LVL_W'(1));
   assign stat.pool_ok   = (need_sum <= POOL_LIMIT);
   assign stat.rsp_busy  = rsp_valid_ff & ~rsp_bus.ready;

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.partner_id = rsp_pid_ff;
   assign rsp_bus.status     = rsp_status_ff;

   always_comb begin
      walk_in       = walk_ff;
      levels_in     = levels_ff;
      node_in       = node_ff;
      id_in         = id_ff;
      nodes_used_in = nodes_used_ff;
      rd_root_in    = rd_root_ff;
      if (accept) begin
         walk_in    = KEY_BITS'(req_bus.key);
         levels_in  = LVL_W'(KEY_BITS);
         node_in    = '0;
         id_in      = ID_BITS'(req_bus.entry_id);
         rd_root_in = 1'b1;
      end else if (cmd.walk_step) begin
         walk_in    = walk_ff << 1;
         levels_in  = levels_ff - LVL_W'(1);
         node_in    = next_node;
         rd_root_in = 1'b0;
      end else if (cmd.alloc) begin
         walk_in       = walk_ff << 1;
         levels_in     = levels_ff - LVL_W'(1);
         node_in       = new_node;
         nodes_used_in = new_node;
         rd_root_in    = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff & ~rsp_bus.ready;
      rsp_pid_in    = rsp_pid_ff;
      rsp_status_in = rsp_status_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_pid_in    = cmd.rsp_use_leaf ? PID_W'(leaf_rd_ff) : '0;
         rsp_status_in = cmd.rsp_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nodes_used_ff <= '0;
         rd_root_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         nodes_used_ff <= nodes_used_in;
         rd_root_ff    <= rd_root_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      walk_ff       <= walk_in;
      levels_ff     <= levels_in;
      node_ff       <= node_in;
      id_ff         <= id_in;
      rsp_pid_ff    <= rsp_pid_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.alloc) begin
         link_mem[node_ff] <= alloc_word;
      end
      if (link_rd_en) begin
         link_rd_ff <= link_mem[link_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (leaf_wr_en) begin
         leaf_mem[leaf_wr_addr] <= id_ff;
      end
      if (cmd.walk_rd_leaf) begin
         leaf_rd_ff <= leaf_mem[next_node];
      end
   end

   a_alloc_count: assert property (@(posedge clock) disable iff (reset)
      !reset && cmd.alloc |=> nodes_used_ff == $past(nodes_used_ff) + NODE_W'(1))
      else $error("pool counter did not advance on allocation");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !reset && !cmd.alloc |=> $stable(nodes_used_ff))
      else $error("pool counter changed without allocation");

   a_alloc_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.alloc |-> nodes_used_ff < NODE_LIMIT)
      else $error("allocation beyond node pool");

   a_rsp_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> !(rsp_valid_ff && !rsp_bus.ready))
      else $error("response register overwritten");

   a_walk_level: assert property (@(posedge clock) disable iff (reset)
      (cmd.walk_step || cmd.alloc) |-> levels_ff != '0)
      else $error("trie walk past the last level");

endmodule

`default_nettype wire

### rtl/btx_ctrl.sv
// Controller of the trie lookup block: sequences walk, pool check,
// node allocation, leaf access and response hand-off.
// Depends on btx_pkg; commands btx_datapath.
`timescale 1ns / 1ps
`default_nettype none

module btx_ctrl
   import btx_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire dp_stat_type stat,
   output ctrl_cmd_type     cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_CHECK,
      ST_ALLOC_FIRST,
      ST_ALLOC,
      ST_LEAF,
      ST_RESP
   } state_type;

   state_type  state_ff, state_in;
   logic       is_query_ff, is_query_in;
   logic       use_leaf_ff, use_leaf_in;
   status_type code_ff, code_in;

   always_comb begin
      cmd              = '0;
      cmd.query_mode   = is_query_ff;
      cmd.rsp_use_leaf = use_leaf_ff;
      cmd.rsp_status   = code_ff;
      state_in         = state_ff;
      is_query_in      = is_query_ff;
      use_leaf_in      = use_leaf_ff;
      code_in          = code_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.accept = 1'b1;
            if (stat.req_valid) begin
               is_query_in = stat.req_query;
               use_leaf_in = 1'b0;
               code_in     = STATUS_OK;
               if (stat.req_query && stat.empty) begin
                  code_in  = STATUS_EMPTY;
                  state_in = ST_RESP;
               end else begin
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            if (!is_query_ff && stat.miss) begin
               state_in = ST_CHECK;
            end else begin
               cmd.walk_step = 1'b1;
               if (!stat.last) begin
                  cmd.walk_rd_link = 1'b1;
               end else if (is_query_ff) begin
                  cmd.walk_rd_leaf = 1'b1;
                  state_in         = ST_LEAF;
               end else begin
                  cmd.walk_wr_leaf = 1'b1;
                  state_in         = ST_RESP;
               end
            end
         end
         ST_CHECK: begin
            if (stat.pool_ok) begin
               state_in = ST_ALLOC_FIRST;
            end else begin
               code_in  = STATUS_FULL;
               state_in = ST_RESP;
            end
         end
         ST_ALLOC_FIRST, ST_ALLOC: begin
            cmd.alloc       = 1'b1;
            cmd.alloc_first = (state_ff == ST_ALLOC_FIRST);
            if (stat.last) begin
               cmd.wr_leaf_new = 1'b1;
               state_in        = ST_RESP;
            end else begin
               state_in = ST_ALLOC;
            end
         end
         ST_LEAF: begin
            use_leaf_in = 1'b1;
            state_in    = ST_RESP;
         end
         ST_RESP: begin
            if (!stat.rsp_busy) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         is_query_ff <= 1'b0;
         use_leaf_ff <= 1'b0;
         code_ff     <= STATUS_OK;
      end else begin
         state_ff    <= state_in;
         is_query_ff <= is_query_in;
         use_leaf_ff <= use_leaf_in;
         code_ff     <= code_in;
      end
   end

endmodule

`default_nettype wire

### rtl/binary_trie_max_xor_lookup_top.sv
// Binary trie maximum-XOR lookup, top level: insert and best-partner query.
// Query: one node memory read per level, then one leaf read.
// Insert: walks the stored path, and when nodes are allocated checks the pool first;
// an empty-trie query goes straight to the response.
// Reset clears the pool counter at once; no memory clearing pass is needed.
// Depends on btx_pkg, btx_if, btx_ctrl and btx_datapath.
`timescale 1ns / 1ps
`default_nettype none

module binary_trie_max_xor_lookup_top
   import btx_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   btx_req_if.sink   req_bus,
   btx_rsp_if.source rsp_bus
);

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   btx_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cmd   (cmd)
   );

   btx_datapath u_datapath (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .cmd     (cmd),
      .stat    (stat)
   );

endmodule

`default_nettype wire

### verif/btx_checker.sv
// Checker for the trie lookup block: watches both channels, keeps its own copy of the trie,
// and compares every response with the oldest expected one.
// Depends on btx_pkg and btx_if.
`timescale 1ns / 1ps

module btx_checker
   import btx_pkg::*;
(
   input  logic clock,
   input  logic reset,
   btx_req_if   req_mon,
   btx_rsp_if   rsp_mon,
   output int   error_count,
   output int   results_waiting,
   output int   pool_nodes,
   output int   results_checked,
   output int   full_refusals
);

   typedef struct packed {
      logic [PID_W-1:0] partner_id;
      status_type       status;
   } lookup_result_t;

   int unsigned    trie_links [NODE_COUNT][2];
   logic [31:0]    leaf_ids [NODE_COUNT];
   int unsigned    trie_nodes_used;
   lookup_result_t expected_results[$];
   int             mismatches;
   int             checked;
   int             refused;

   function automatic int unsigned nodes_to_allocate(logic [63:0] k);
      int unsigned node;
      node = 0;
      for (int lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
         if (trie_links[node][k[lvl]] == 0) return unsigned'(lvl + 1);
         node = trie_links[node][k[lvl]];
      end
      return 0;
   endfunction

   function automatic void store_key(logic [63:0] k, logic [31:0] id);
      int unsigned node;
      node = 0;
      for (int lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
         if (trie_links[node][k[lvl]] == 0) begin
            trie_nodes_used++;
            trie_links[node][k[lvl]] = trie_nodes_used;
         end
         node = trie_links[node][k[lvl]];
      end
      leaf_ids[node] = id;
   endfunction

   function automatic logic [31:0] best_xor_partner(logic [63:0] k);
      int unsigned node;
      int unsigned other;
      node = 0;
      for (int lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
         other = trie_links[node][!k[lvl]];
         node  = (other != 0) ? other : trie_links[node][k[lvl]];
      end
      return leaf_ids[node];
   endfunction

   function automatic lookup_result_t predict_lookup(logic op, logic [KEY_W-1:0] key,
                                                     logic [EID_W-1:0] id);
      lookup_result_t res;
      logic [63:0]    k;
      logic [63:0]    idm;
      k   = 64'(key);
      if (KEY_BITS < 64) k &= (64'd1 << KEY_BITS) - 64'd1;
      idm = 64'(id) & ((64'd1 << ID_BITS) - 64'd1);
      res.partner_id = '0;
      res.status     = STATUS_OK;
      if (op == CMD_INSERT) begin
         if (longint'(trie_nodes_used) + longint'(nodes_to_allocate(k))
             > longint'(NODE_COUNT - 1))
            res.status = STATUS_FULL;
         else
            store_key(k, idm[31:0]);
      end else if (trie_nodes_used == 0) begin
         res.status = STATUS_EMPTY;
      end else begin
         res.partner_id = PID_W'(best_xor_partner(k));
      end
      return res;
   endfunction

   always @(posedge clock) begin
      lookup_result_t want;
      if (reset) begin
         foreach (trie_links[i]) begin
            trie_links[i][0] = 0;
            trie_links[i][1] = 0;
            leaf_ids[i]      = '0;
         end
         trie_nodes_used = 0;
         expected_results.delete();
         mismatches = 0;
         checked    = 0;
         refused    = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            checked++;
            if (expected_results.size() == 0) begin
               if (mismatches < 10)
                  $display("%t: unexpected response partner_id %h status %0d", $realtime,
                           rsp_mon.partner_id, rsp_mon.status);
               mismatches++;
            end else begin
               want = expected_results.pop_front();
               if (want.partner_id !== rsp_mon.partner_id || want.status !== rsp_mon.status)
               begin
                  if (mismatches < 10)
                     $display("%t: mismatch: expected partner_id %h status %0d, got %h %0d",
                              $realtime, want.partner_id, want.status,
                              rsp_mon.partner_id, rsp_mon.status);
                  mismatches++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            want = predict_lookup(req_mon.cmd, req_mon.key, req_mon.entry_id);
            if (want.status == STATUS_FULL) refused++;
            expected_results.insert(expected_results.size(), want);
         end
      end
      error_count     <= mismatches;
      results_waiting <= expected_results.size();
      pool_nodes      <= trie_nodes_used;
      results_checked <= checked;
      full_refusals   <= refused;
   end

endmodule

### verif/tb_top.sv
// Testbench top for the trie lookup block: clock, reset, stimulus and verdict.
// Depends on btx_pkg, btx_if, btx_checker and binary_trie_max_xor_lookup_top.
`timescale 1ns / 1ps

module tb_top;
   import btx_pkg::*;

   localparam int STALL_LIMIT  = 2000;
   localparam int RANDOM_ITEMS = 828;
   localparam int DRAIN_CYCLES = KEY_BITS + 8;

   logic clock;
   logic reset;
   logic quiet;
   int   errors;
   int   waiting;
   int   pool_nodes;
   int   results_seen;
   int   full_refusals;
   int   inserts_sent;
   int   queries_sent;
   int   stall_cycles;
   logic [KEY_W-1:0] stored_keys[$];

   btx_req_if req_bus();
   btx_rsp_if rsp_bus();

   binary_trie_max_xor_lookup_top uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   btx_checker lookup_check (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_bus),
      .rsp_mon         (rsp_bus),
      .error_count     (errors),
      .results_waiting (waiting),
      .pool_nodes      (pool_nodes),
      .results_checked (results_seen),
      .full_refusals   (full_refusals)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset)
         rsp_bus.ready <= 1'b0;
      else
         rsp_bus.ready <= quiet || ($urandom_range(99) >= 15);
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic send_item(input logic op, input logic [KEY_W-1:0] k,
                            input logic [EID_W-1:0] id);
      while (!quiet && $urandom_range(99) < 15) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.cmd      <= op;
      req_bus.key      <= k;
      req_bus.entry_id <= id;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      if (op == CMD_INSERT) begin
         inserts_sent++;
         stored_keys.insert(stored_keys.size(), k);
      end else begin
         queries_sent++;
      end
   endtask

   task automatic hold_until_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (waiting != 0) @(posedge clock);
   endtask

   function automatic logic [KEY_W-1:0] near_stored_key(input int span);
      logic [KEY_W-1:0] k;
      if (stored_keys.size() == 0) return KEY_W'($urandom);
      k = stored_keys[$urandom_range(stored_keys.size() - 1)];
      return k ^ (KEY_W'(1) << $urandom_range(span - 1));
   endfunction

   function automatic logic [KEY_W-1:0] pick_key();
      case ($urandom_range(9))
         0:       return $urandom_range(1) ? '1 : '0;
         1, 2:    return near_stored_key(8);
         3:       return near_stored_key(KEY_W);
         4:       return (stored_keys.size() != 0)
                         ? stored_keys[$urandom_range(stored_keys.size() - 1)] : '0;
         default: return KEY_W'($urandom);
      endcase
   endfunction

   initial begin
      reset            = 1'b1;
      quiet            = 1'b0;
      req_bus.valid    = 1'b0;
      req_bus.cmd      = CMD_INSERT;
      req_bus.key      = '0;
      req_bus.entry_id = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty trie, zero id, overwrite, extreme keys and ids
      send_item(CMD_QUERY,  32'h0000_0000, 16'hFFFF);
      send_item(CMD_QUERY,  32'hFFFF_FFFF, 16'h0000);
      send_item(CMD_INSERT, 32'h0000_0000, 16'h0000);
      send_item(CMD_QUERY,  32'hFFFF_FFFF, 16'h0000);
      send_item(CMD_QUERY,  32'h0000_0000, 16'h0000);
      send_item(CMD_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
      send_item(CMD_QUERY,  32'h0000_0000, 16'h0000);
      send_item(CMD_QUERY,  32'hFFFF_FFFF, 16'hFFFF);
      send_item(CMD_INSERT, 32'h0000_0000, 16'h1234);
      send_item(CMD_QUERY,  32'hFFFF_FFFF, 16'h0000);
      send_item(CMD_INSERT, 32'h8000_0000, 16'h8001);
      send_item(CMD_INSERT, 32'h7FFF_FFFF, 16'h7FFE);
      send_item(CMD_QUERY,  32'h8000_0000, 16'h0000);
      send_item(CMD_QUERY,  32'h7FFF_FFFF, 16'h0000);
      send_item(CMD_INSERT, 32'h0000_0001, 16'h0001);
      send_item(CMD_QUERY,  32'hFFFF_FFFE, 16'h0000);
      send_item(CMD_INSERT, 32'hA5A5_A5A5, 16'h5A5A);
      send_item(CMD_INSERT, 32'h5A5A_5A5A, 16'hA5A5);
      send_item(CMD_QUERY,  32'hA5A5_A5A5, 16'h0000);
      send_item(CMD_QUERY,  32'h5A5A_5A5A, 16'h0000);
      send_item(CMD_INSERT, 32'hFFFF_FFFF, 16'h0000);
      send_item(CMD_QUERY,  32'h0000_0000, 16'hFFFF);
      hold_until_drained();

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         quiet <= (i >= 300 && i < 500);
         send_item(logic'($urandom_range(1)), pick_key(), EID_W'($urandom));
      end
      quiet <= 1'b0;

      hold_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d inserts and %0d queries; %0d responses checked, %0d refused as pool full.",
               inserts_sent, queries_sent, results_seen, full_refusals);
      $display("Node pool ended at %0d of %0d nodes.", pool_nodes, NODE_COUNT - 1);
      if (errors == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

endmodule
